// ===== design/tcs_pkg.sv =====
package tcs_pkg;

  // effective mode codes, anything above pause is safety
  localparam logic [3:0] MODE_AUTO   = 4'd0;
  localparam logic [3:0] MODE_MANUAL = 4'd1;
  localparam logic [3:0] MODE_PAUSE  = 4'd2;
  localparam logic [3:0] MODE_SAFETY = 4'd9;

  localparam logic [11:0] NEUTRAL_RESET  = 12'd2836;
  localparam logic [3:0]  BUCKET_RESET   = 4'd5;
  localparam logic [3:0]  BUCKET_AUTO    = 4'd5;
  localparam logic [3:0]  BUCKET_FAULT   = 4'd4;
  localparam int          BUCKET_COUNT   = 10;
  localparam int          LADDER_STEPS   = BUCKET_COUNT - 1;

  // speed breakpoints in mm/s and their targets
  localparam logic signed [15:0] SPD_X0 = 16'sd0;
  localparam logic signed [15:0] SPD_X1 = 16'sd400;
  localparam logic signed [15:0] SPD_X2 = 16'sd750;
  localparam logic signed [15:0] SPD_X3 = 16'sd1000;
  localparam logic signed [15:0] SPD_X4 = 16'sd1200;
  localparam logic signed [15:0] SPD_X5 = 16'sd1500;

  localparam logic [11:0] SPD_Y0 = 12'd2836;
  localparam logic [11:0] SPD_Y1 = 12'd2452;
  localparam logic [11:0] SPD_Y2 = 12'd2350;
  localparam logic [11:0] SPD_Y3 = 12'd2300;
  localparam logic [11:0] SPD_Y4 = 12'd2246;
  localparam logic [11:0] SPD_Y5 = 12'd2160;

  // reciprocal scaling for the rounded segment division
  localparam int RECIP_SHIFT = 30;
  localparam int OFF_W       = 9;
  localparam int COEF_W      = 30;
  localparam int PROD_W      = OFF_W + COEF_W + 1;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  // per segment: slope term 2*dy*ceil(2^30/(2*dx)) and bias (dx-1)*ceil(2^30/(2*dx))
  localparam logic [COEF_W-1:0] SEG1_K = 30'd1030792704;
  localparam logic [COEF_W-1:0] SEG1_C = 30'd535529022;
  localparam logic [COEF_W-1:0] SEG2_K = 30'd312919068;
  localparam logic [COEF_W-1:0] SEG2_C = 30'd535337033;
  localparam logic [COEF_W-1:0] SEG3_K = 30'd214748400;
  localparam logic [COEF_W-1:0] SEG3_C = 30'd534723516;
  localparam logic [COEF_W-1:0] SEG4_K = 30'd289910340;
  localparam logic [COEF_W-1:0] SEG4_C = 30'd534186645;
  localparam logic [COEF_W-1:0] SEG5_K = 30'd307806040;
  localparam logic [COEF_W-1:0] SEG5_C = 30'd535081430;

  typedef struct packed {
    logic [3:0]         mode;
    logic               link_good;
    logic               speed_valid;
    logic signed [15:0] speed_mm_s;
    logic [9:0]         lever_position;
    logic               fault_latched;
    logic               manual_steer_ok;
  } cmd_t;

  typedef struct packed {
    logic [11:0] target;
    logic [3:0]  bucket_out;
    logic        fault_clear;
  } result_t;

  // lever threshold ladder, highest reading is bucket 0
  function automatic logic [3:0] lever_bucket(input logic [9:0] lever);
    logic [3:0] b;
    b = 4'd9;
    if      (lever >= 10'd931) b = 4'd0;
    else if (lever >= 10'd838) b = 4'd1;
    else if (lever >= 10'd746) b = 4'd2;
    else if (lever >= 10'd654) b = 4'd3;
    else if (lever >= 10'd562) b = 4'd4;
    else if (lever >= 10'd469) b = 4'd5;
    else if (lever >= 10'd377) b = 4'd6;
    else if (lever >= 10'd285) b = 4'd7;
    else if (lever >= 10'd192) b = 4'd8;
    return b;
  endfunction

  // fixed calibration targets per bucket
  function automatic logic [11:0] bucket_target(input logic [3:0] b);
    logic [11:0] t;
    case (b)
      4'd0:    t = 12'd3138;
      4'd1:    t = 12'd3063;
      4'd2:    t = 12'd2987;
      4'd3:    t = 12'd2912;
      4'd4:    t = 12'd2836;
      4'd5:    t = 12'd2616;
      4'd6:    t = 12'd2534;
      4'd7:    t = 12'd2452;
      4'd8:    t = 12'd2370;
      default: t = 12'd2288;
    endcase
    return t;
  endfunction

endpackage

// ===== design/transmission_command_selector_unit.sv =====
// transmission command selector
// cmd channel (cmd_valid/cmd_ready/cmd) carries one control tick per transaction:
// mode, link status, speed command, lever reading and steering fault signals.
// res channel (res_valid/res_ready/res) returns one transaction per tick with
// the actuator target, the bucket number and the fault clear pulse.
// cfg_we/cfg_data write the neutral target; write it only while no tick is in flight.
// the block has an input register and a result register with the speed
// interpolation, lever ladder and fault logic between them; one multiply by a
// segment constant does the rounded division of the interpolation.
// a tick waits in the input register and moves to the result register when that
// register is free or its result is taken in the same cycle.
// throughput: one tick per cycle while the receiver takes results, set by the single register stage per side.
// when the receiver stalls the result holds, one more tick is taken into the
// input register, then cmd_ready drops until the result is taken.
// reset clears both valid flags, sets the bucket to 5, clears the pause flag
// and loads the neutral target with 2836.
module transmission_command_selector_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  tcs_pkg::cmd_t    cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output tcs_pkg::result_t res,
  input  logic             cfg_we,
  input  logic [11:0]      cfg_data
);

  logic                 cmd_q_valid;
  tcs_pkg::cmd_t        cmd_q;
  logic [11:0]          neutral_target;
  logic [3:0]           bucket_reg;
  logic                 pause_seen;
  logic                 advance;

  logic [3:0]           bucket_next;
  logic                 pause_seen_next;
  tcs_pkg::result_t     res_next;

  logic [3:0]                    mode_eff;
  logic [tcs_pkg::OFF_W-1:0]     seg_off;
  logic [tcs_pkg::COEF_W-1:0]    seg_k;
  logic [tcs_pkg::COEF_W-1:0]    seg_c;
  logic [11:0]                   seg_y0;
  logic [tcs_pkg::PROD_W-1:0]    seg_prod;
  logic [tcs_pkg::QUO_W-1:0]     seg_q;
  logic [11:0]                   speed_target;
  logic [3:0]                    lever_b;
  logic [11:0]                   manual_target;
  logic [11:0]                   target;
  logic [3:0]                    bucket;
  logic                          clear;

  // handshake: the input register moves on whenever the result register is free
  assign advance   = cmd_q_valid && (!res_valid || res_ready);
  assign cmd_ready = !cmd_q_valid || !res_valid || res_ready;

  // segment choice and constants for the speed interpolation
  always_comb begin
    seg_off = '0;
    seg_k   = tcs_pkg::SEG1_K;
    seg_c   = tcs_pkg::SEG1_C;
    seg_y0  = tcs_pkg::SPD_Y0;
    if (cmd_q.speed_mm_s <= tcs_pkg::SPD_X1) begin
      seg_off = tcs_pkg::OFF_W'(cmd_q.speed_mm_s - tcs_pkg::SPD_X0);
    end else if (cmd_q.speed_mm_s <= tcs_pkg::SPD_X2) begin
      seg_off = tcs_pkg::OFF_W'(cmd_q.speed_mm_s - tcs_pkg::SPD_X1);
      seg_k   = tcs_pkg::SEG2_K;
      seg_c   = tcs_pkg::SEG2_C;
      seg_y0  = tcs_pkg::SPD_Y1;
    end else if (cmd_q.speed_mm_s <= tcs_pkg::SPD_X3) begin
      seg_off = tcs_pkg::OFF_W'(cmd_q.speed_mm_s - tcs_pkg::SPD_X2);
      seg_k   = tcs_pkg::SEG3_K;
      seg_c   = tcs_pkg::SEG3_C;
      seg_y0  = tcs_pkg::SPD_Y2;
    end else if (cmd_q.speed_mm_s <= tcs_pkg::SPD_X4) begin
      seg_off = tcs_pkg::OFF_W'(cmd_q.speed_mm_s - tcs_pkg::SPD_X3);
      seg_k   = tcs_pkg::SEG4_K;
      seg_c   = tcs_pkg::SEG4_C;
      seg_y0  = tcs_pkg::SPD_Y3;
    end else begin
      seg_off = tcs_pkg::OFF_W'(cmd_q.speed_mm_s - tcs_pkg::SPD_X4);
      seg_k   = tcs_pkg::SEG5_K;
      seg_c   = tcs_pkg::SEG5_C;
      seg_y0  = tcs_pkg::SPD_Y4;
    end
  end

  // rounded drop below the segment start, via scaled reciprocal
  assign seg_prod = tcs_pkg::PROD_W'(seg_off) * tcs_pkg::PROD_W'(seg_k)
                  + tcs_pkg::PROD_W'(seg_c);
  assign seg_q    = seg_prod[tcs_pkg::PROD_W-1:tcs_pkg::RECIP_SHIFT];

  // clamp at both ends of the speed table
  always_comb begin
    if (cmd_q.speed_mm_s <= tcs_pkg::SPD_X0) begin
      speed_target = tcs_pkg::SPD_Y0;
    end else if (cmd_q.speed_mm_s >= tcs_pkg::SPD_X5) begin
      speed_target = tcs_pkg::SPD_Y5;
    end else begin
      speed_target = seg_y0 - 12'(seg_q);
    end
  end

  // manual lever ladder
  assign lever_b       = tcs_pkg::lever_bucket(cmd_q.lever_position);
  assign manual_target = tcs_pkg::bucket_target(lever_b);

  // mode selection and fault hold
  always_comb begin
    mode_eff        = cmd_q.link_good ? cmd_q.mode : tcs_pkg::MODE_SAFETY;
    target          = neutral_target;
    bucket          = bucket_reg;
    clear           = 1'b0;
    pause_seen_next = pause_seen;
    if (mode_eff == tcs_pkg::MODE_AUTO) begin
      target = cmd_q.speed_valid ? speed_target : neutral_target;
      bucket = tcs_pkg::BUCKET_AUTO;
    end else if (mode_eff == tcs_pkg::MODE_MANUAL) begin
      target = manual_target;
      bucket = lever_b;
    end
    if (cmd_q.fault_latched) begin
      if (mode_eff == tcs_pkg::MODE_PAUSE) begin
        pause_seen_next = 1'b1;
      end
      if (mode_eff == tcs_pkg::MODE_MANUAL && pause_seen && cmd_q.manual_steer_ok &&
          target == neutral_target) begin
        clear           = 1'b1;
        pause_seen_next = 1'b0;
      end else begin
        target = neutral_target;
        bucket = tcs_pkg::BUCKET_FAULT;
      end
    end
    bucket_next          = bucket;
    res_next.target      = target;
    res_next.bucket_out  = bucket;
    res_next.fault_clear = clear;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid    <= 1'b0;
      res_valid      <= 1'b0;
      neutral_target <= tcs_pkg::NEUTRAL_RESET;
      bucket_reg     <= tcs_pkg::BUCKET_RESET;
      pause_seen     <= 1'b0;
    end else begin
      if (cfg_we) begin
        neutral_target <= cfg_data;
      end
      if (cmd_valid && cmd_ready) begin
        cmd_q_valid <= 1'b1;
      end else if (advance) begin
        cmd_q_valid <= 1'b0;
      end
      if (advance) begin
        res_valid  <= 1'b1;
        bucket_reg <= bucket_next;
        pause_seen <= pause_seen_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  // a clear pulse only comes with the neutral target passed through
  a_clear_neutral: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.fault_clear |-> res.target == neutral_target)
    else $error("fault clear with non-neutral target");

  // the reported bucket is the stored bucket
  a_bucket_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.bucket_out == bucket_reg)
    else $error("bucket output differs from bucket register");

  // pause flag drops only through a recovery transaction
  a_pause_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(pause_seen) |-> $past(rst) || (res_valid && res.fault_clear))
    else $error("pause flag cleared without recovery");

  // an empty result register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("input stalled with free result register");

endmodule
